>>> src/sacl_pkg.sv
// ---------------------------------------------------------------------------
// sacl_pkg - shared types and constants of the set-associative cache
// fixed field widths, age counter width and the result record
// ---------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

	localparam int ADDR_W   = 32;
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 2;
	localparam int WIDE_W   = 64;
	localparam int AGE_W    = 8;
	localparam int IDX_LIMIT_W = 13;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// bit positions inside req_type
	localparam int REQ_READ_BIT = 0;

	typedef struct packed {
		logic              hit;
		logic              data_valid;
		logic [DATA_W-1:0] read_data;
	} sacl_result_t;

endpackage

`default_nettype wire

>>> src/sacl_if.sv
// ---------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if - request and response channels
// valid/ready handshake, transaction moves on valid && ready
// ---------------------------------------------------------------------------
`default_nettype none

interface sacl_req_if
	import sacl_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] fill_data;

	modport source (output valid, req_type, address, fill_data, input ready);
	modport sink   (input valid, req_type, address, fill_data, output ready);
endinterface

interface sacl_rsp_if
	import sacl_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              hit;
	logic              data_valid;
	logic [DATA_W-1:0] read_data;

	modport source (output valid, hit, data_valid, read_data, input ready);
	modport sink   (input valid, hit, data_valid, read_data, output ready);
endinterface

`default_nettype wire

>>> src/sacl_lookup.sv
// ---------------------------------------------------------------------------
// sacl_lookup - tag compare, victim choice and set row update
// works on one full set row as read from the set memory
// ---------------------------------------------------------------------------
`default_nettype none

module sacl_lookup
	import sacl_pkg::*;
#(
	parameter int WAY_COUNT = 2,
	parameter int TAG_W     = 25,
	parameter int WORD_BITS = 32
) (
	input  wire logic [WAY_COUNT*(1+TAG_W+WORD_BITS+AGE_W)-1:0] row,
	input  wire logic [TAG_W-1:0]                              tag,
	input  wire logic [WORD_BITS-1:0]                          fill,
	input  wire logic                                          is_read,
	output logic                                               row_we,
	output logic [WAY_COUNT*(1+TAG_W+WORD_BITS+AGE_W)-1:0]     row_new,
	output sacl_result_t                                       result
);

	localparam int WAY_W = 1 + TAG_W + WORD_BITS + AGE_W;
	localparam int WI    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

	logic                 vld   [WAY_COUNT];
	logic [TAG_W-1:0]     tags  [WAY_COUNT];
	logic [WORD_BITS-1:0] words [WAY_COUNT];
	logic [AGE_W-1:0]     ages  [WAY_COUNT];

	logic                 found;
	logic [WI-1:0]        hit_way;
	logic [WI-1:0]        victim;
	logic [WI-1:0]        used;
	logic [AGE_W-1:0]     best;
	logic [WORD_BITS-1:0] data;
	logic [WIDE_W-1:0]    data_wide;

	always_comb begin
		for (int w = 0; w < WAY_COUNT; w++) begin
			ages[w]  = row[w*WAY_W +: AGE_W];
			words[w] = row[w*WAY_W + AGE_W +: WORD_BITS];
			tags[w]  = row[w*WAY_W + AGE_W + WORD_BITS +: TAG_W];
			vld[w]   = row[w*WAY_W + WAY_W - 1];
		end
	end

	// first matching way wins
	always_comb begin
		found   = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (!found && vld[w] && (tags[w] == tag)) begin
				found   = 1'b1;
				hit_way = WI'(w);
			end
		end
	end

	// oldest way, lowest index on ties
	always_comb begin
		best   = ages[0];
		victim = '0;
		for (int w = 1; w < WAY_COUNT; w++) begin
			if (ages[w] > best) begin
				best   = ages[w];
				victim = WI'(w);
			end
		end
	end

	assign used   = found ? hit_way : victim;
	assign row_we = found || is_read;

	always_comb begin
		row_new = row;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (WI'(w) == used) begin
				row_new[w*WAY_W +: AGE_W] = '0;
				if (!found) begin
					row_new[w*WAY_W + AGE_W +: WORD_BITS]         = fill;
					row_new[w*WAY_W + AGE_W + WORD_BITS +: TAG_W] = tag;
					row_new[w*WAY_W + WAY_W - 1]                  = 1'b1;
				end
			end else if (ages[w] != AGE_MAX) begin
				row_new[w*WAY_W +: AGE_W] = ages[w] + AGE_W'(1);
			end
		end
	end

	assign data      = found ? words[hit_way] : fill;
	assign data_wide = WIDE_W'(data);

	always_comb begin
		result.hit        = found;
		result.data_valid = is_read;
		result.read_data  = is_read ? data_wide[DATA_W-1:0] : '0;
	end

endmodule

`default_nettype wire

>>> src/set_assoc_cache_lru.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_lru - set-associative word cache with age-based LRU
// one set memory row holds valid, tag, word and age of every way
// ---------------------------------------------------------------------------
// Usage: after reset the block runs a clearing pass over the set memory,
// one set per cycle over all SET_COUNT sets (128 by default), with req.ready
// low. After that each transaction reads the set row (in the accept cycle
// when no folding is needed), then the lookup state compares tags, picks
// the way and writes the row back, so the single set memory
// read-modify-write sets the rate; a new request is taken only after that
// write-back. When SET_COUNT is smaller than 2**SET_BITS the set number is
// folded by a reciprocal multiply and one compare and subtract (not needed
// by default). A response waiting in the output register does not block the
// next accept; the lookup stage only waits if the previous response is still there when it finishes.
`default_nettype none

module set_assoc_cache_lru
	import sacl_pkg::*;
#(
	parameter int SET_COUNT = 128,
	parameter int WAY_COUNT = 2,
	parameter int SET_BITS  = 7,
	parameter int WORD_BITS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sacl_req_if.sink    req,
	sacl_rsp_if.source  rsp
);

	localparam int TAG_W     = ADDR_W - SET_BITS;
	localparam int WAY_W     = 1 + TAG_W + WORD_BITS + AGE_W;
	localparam int ROW_W     = WAY_COUNT * WAY_W;
	localparam int SI_W      = $clog2(SET_COUNT);
	localparam int IW        = (SET_BITS > SI_W) ? SET_BITS : SI_W;
	localparam int RW        = SET_BITS + 1;
	localparam int PW        = 2 * SET_BITS;
	localparam int RED_STEPS = (SET_COUNT < (1 << SET_BITS)) ? 2 : 0;
	localparam int RECIP     = (1 << SET_BITS) / SET_COUNT;
	localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

	// sequencer states
	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_REDUCE = 2'd2;
	localparam logic [1:0] ST_LOOKUP = 2'd3;

	logic [1:0]          state_q;
	logic [SI_W-1:0]     clr_q;
	logic [STEP_W-1:0]   step_q;
	logic [SET_BITS-1:0] rem_q;
	logic [SET_BITS-1:0] quo_q;

	// request held for the lookup
	logic                 rd_q;
	logic [TAG_W-1:0]     tag_q;
	logic [WORD_BITS-1:0] fill_q;
	logic [SI_W-1:0]      set_q;

	// set memory
	logic [ROW_W-1:0] mem_q [SET_COUNT];
	logic [ROW_W-1:0] rd_row_q;
	logic             rd_en;
	logic [SI_W-1:0]  rd_idx;
	logic             mem_we;
	logic [SI_W-1:0]  wr_idx;
	logic [ROW_W-1:0] wr_row;
	logic [ROW_W-1:0] clr_row;

	// output register
	logic         out_valid_q;
	sacl_result_t res_q;

	logic                accept;
	logic                finish;
	logic [IW-1:0]       acc_wide;
	logic [IW-1:0]       red_wide;
	logic [PW-1:0]       fold_prod;
	logic [PW-1:0]       fold_back;
	logic [SET_BITS-1:0] rem_est;
	logic [RW-1:0]       rem_ext;
	logic [RW-1:0]       divisor;
	logic [RW-1:0]       rem_sub;
	logic [WIDE_W-1:0]   fill_wide;
	logic                lk_we;
	logic [ROW_W-1:0]    lk_row;
	sacl_result_t        lk_res;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign finish    = (state_q == ST_LOOKUP) && (!out_valid_q || rsp.ready);

	// set number straight from the address, valid when no folding is needed
	assign acc_wide  = IW'(req.address[SET_BITS-1:0]);

	// quotient estimate from the reciprocal, low by at most one
	assign fold_prod = PW'(rem_q) * PW'(RECIP);

	// remainder estimate stays below 2 * SET_COUNT, one compare and subtract ends it
	assign fold_back = PW'(quo_q) * PW'(SET_COUNT);
	assign rem_est   = rem_q - fold_back[SET_BITS-1:0];
	assign rem_ext   = {1'b0, rem_est};
	assign divisor   = RW'(SET_COUNT);
	assign rem_sub   = (rem_ext >= divisor) ? (rem_ext - divisor) : rem_ext;
	assign red_wide  = IW'(rem_sub[SET_BITS-1:0]);

	assign fill_wide = WIDE_W'(req.fill_data);

	// set row read is issued once the set number is known
	assign rd_en  = (accept && (RED_STEPS == 0))
		|| ((state_q == ST_REDUCE) && (step_q == '0));
	assign rd_idx = (state_q == ST_IDLE) ? acc_wide[SI_W-1:0] : red_wide[SI_W-1:0];

	// reset row: everything zero, ages equal to the way number
	for (genvar g = 0; g < WAY_COUNT; g++) begin : g_clr
		assign clr_row[g*WAY_W +: WAY_W] = WAY_W'(g);
	end

	sacl_lookup #(
		.WAY_COUNT (WAY_COUNT),
		.TAG_W     (TAG_W),
		.WORD_BITS (WORD_BITS)
	) u_lookup (
		.row     (rd_row_q),
		.tag     (tag_q),
		.fill    (fill_q),
		.is_read (rd_q),
		.row_we  (lk_we),
		.row_new (lk_row),
		.result  (lk_res)
	);

	// clearing pass owns the write port, otherwise lookup write-back
	assign mem_we = (state_q == ST_CLEAR) || (finish && lk_we);
	assign wr_idx = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign wr_row = (state_q == ST_CLEAR) ? clr_row : lk_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_idx] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem_q[rd_idx];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == SI_W'(SET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + SI_W'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						if (RED_STEPS == 0) begin
							state_q <= ST_LOOKUP;
						end else begin
							state_q <= ST_REDUCE;
							step_q  <= STEP_W'(RED_STEPS - 1);
						end
					end
				end
				ST_REDUCE: begin
					if (step_q == '0) begin
						state_q <= ST_LOOKUP;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_LOOKUP: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= req.req_type[REQ_READ_BIT];
			tag_q  <= req.address[ADDR_W-1:SET_BITS];
			fill_q <= fill_wide[WORD_BITS-1:0];
			rem_q  <= req.address[SET_BITS-1:0];
		end
		if ((state_q == ST_REDUCE) && (step_q != '0)) begin
			quo_q <= fold_prod[PW-1:SET_BITS];
		end
		if (rd_en) begin
			set_q <= rd_idx;
		end
		if (finish) begin
			res_q <= lk_res;
		end
	end

	// output register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = res_q.hit;
	assign rsp.data_valid = res_q.data_valid;
	assign rsp.read_data  = res_q.read_data;

`ifndef ASSERT_OFF
	// read and write-back of the set memory never share a cycle
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && mem_we))
		else $error("set memory read and write in the same cycle");

	// folded set number always addresses an existing set
	a_set_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (int'(rd_idx) < SET_COUNT))
		else $error("set index out of range");

	// a finished lookup shows up on the response channel next cycle
	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp.valid)
		else $error("finished lookup without a response");
`endif

endmodule

`default_nettype wire

>>> verif/set_assoc_cache_lru_test.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_test - self-checking bench for the two-way LRU cache
// a shadow copy of the sets predicts hit, data_valid and read_data for every
// accepted request; directed corner cases, an age saturation burst and
// random traffic over a small tag pool run with random idling on both sides
// ---------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_test;
	import sacl_pkg::*;

	// geometry of the default build
	localparam int N_SETS = 128;
	localparam int N_WAYS = 2;
	localparam int SET_W  = 7;
	localparam int TAG_W  = ADDR_W - SET_W;

	// req_type codes
	localparam logic [REQ_W-1:0] REQ_LOOKUP     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ       = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE      = 2'd2;
	localparam logic [REQ_W-1:0] REQ_READ_WRITE = 2'd3;

	// run shape
	localparam int RANDOM_ACCESSES = 900;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int SATURATE_HITS   = 270;
	localparam int IDLE_PERCENT    = 20;
	localparam int QUIET_LIMIT     = 2000;
	localparam int TAIL_CYCLES     = 20;

	// shadow copy of the cache: predicts one response per accepted request
	class cache_shadow;
		bit [DATA_W-1:0] line_word [N_SETS*N_WAYS];
		bit [TAG_W-1:0]  line_tag  [N_SETS*N_WAYS];
		bit              line_live [N_SETS*N_WAYS];
		bit [AGE_W-1:0]  line_age  [N_SETS*N_WAYS];
		sacl_result_t    pending_responses[$];
		int mismatches;
		int checked;
		int hits;
		int fills;
		int saturations;

		function new();
			for (int i = 0; i < N_SETS*N_WAYS; i++) begin
				line_age[i] = AGE_W'(i % N_WAYS);
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		// used way goes to age 0, every other way ages by one, saturating
		function void touch(int base, int used);
			for (int w = 0; w < N_WAYS; w++) begin
				if (w == used) begin
					line_age[base+w] = '0;
				end else if (line_age[base+w] == AGE_MAX) begin
					saturations++;
				end else begin
					line_age[base+w] = line_age[base+w] + 1'b1;
				end
			end
		endfunction

		function void note_access(bit [REQ_W-1:0] kind, bit [ADDR_W-1:0] addr,
				bit [DATA_W-1:0] fill);
			int base;
			int way;
			bit found;
			bit rd;
			bit [TAG_W-1:0] tag;
			bit [AGE_W-1:0] best;
			sacl_result_t r;
			base  = int'(addr[SET_W-1:0]) * N_WAYS;
			tag   = addr[ADDR_W-1:SET_W];
			rd    = kind[REQ_READ_BIT];
			found = 1'b0;
			way   = 0;
			for (int w = 0; w < N_WAYS; w++) begin
				if (!found && line_live[base+w] && line_tag[base+w] == tag) begin
					found = 1'b1;
					way   = w;
				end
			end
			r.hit        = found;
			r.data_valid = rd;
			r.read_data  = '0;
			if (found) begin
				hits++;
				if (rd) r.read_data = line_word[base+way];
				touch(base, way);
			end else if (rd) begin
				// victim is the oldest way, lowest index on a tie
				way  = 0;
				best = line_age[base];
				for (int w = 1; w < N_WAYS; w++) begin
					if (line_age[base+w] > best) begin
						best = line_age[base+w];
						way  = w;
					end
				end
				line_word[base+way] = fill;
				line_tag[base+way]  = tag;
				line_live[base+way] = 1'b1;
				touch(base, way);
				r.read_data = fill;
				fills++;
			end
			pending_responses.push_back(r);
		endfunction

		task check_response(logic h, logic dv, logic [DATA_W-1:0] rdata);
			sacl_result_t want;
			if (pending_responses.size() == 0) begin
				report($sformatf("response with nothing pending: hit=%b data_valid=%b data=%h",
					h, dv, rdata));
			end else begin
				want = pending_responses.pop_front();
				checked++;
				if (h !== want.hit)
					report($sformatf("response %0d hit %b, want %b", checked, h, want.hit));
				if (dv !== want.data_valid)
					report($sformatf("response %0d data_valid %b, want %b", checked, dv,
						want.data_valid));
				if (rdata !== want.read_data)
					report($sformatf("response %0d read_data %h, want %h", checked, rdata,
						want.read_data));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sacl_req_if req_ch ();
	sacl_rsp_if rsp_ch ();

	set_assoc_cache_lru dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cache_shadow shadow;
	bit jitter      = 1'b1;    // random idling on both sides when set
	int hold_left   = 0;       // cycles the receiver still holds off
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	// request driver: optional random gap, then offer until accepted
	// valid stays high after acceptance so back-to-back transactions need no bubble
	task automatic send_access(input bit [REQ_W-1:0] kind, input bit [ADDR_W-1:0] addr,
			input bit [DATA_W-1:0] fill);
		if (jitter && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.address   <= addr;
		req_ch.fill_data <= fill;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		shadow.note_access(kind, addr, fill);
	endtask

	// drop valid and wait until every predicted response has come back
	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		while (shadow.pending_responses.size() != 0) @(posedge clk);
	endtask

	// response side: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= !jitter || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// response monitor, samples pre-edge values
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			shadow.check_response(rsp_ch.hit, rsp_ch.data_valid, rsp_ch.read_data);
	end

	// watchdog: any stretch with no transaction on either side too long ends the run
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("set_assoc_cache_lru_test failed");
				$finish;
			end
		end
	end

	initial begin
		bit [TAG_W-1:0]  tag_pool [4];
		bit [ADDR_W-1:0] addr;
		bit [ADDR_W-1:0] hot_a;
		bit [ADDR_W-1:0] hot_b;
		bit [ADDR_W-1:0] hot_c;
		bit [REQ_W-1:0]  kind;

		shadow = new();
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_LOOKUP;
		req_ch.address   <= '0;
		req_ch.fill_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: misses on a cleared store, fill, hits of every kind, eviction
		send_access(REQ_LOOKUP, 32'h0000_0000, 32'h1111_1111);  // lookup miss, tag 0 not valid
		send_access(REQ_WRITE, 32'h0000_0000, 32'h2222_2222);   // write miss, no change
		send_access(REQ_READ, 32'h0000_0000, 32'hA5A5_5A5A);    // read miss fills oldest way
		send_access(REQ_READ, 32'h0000_0000, 32'h0BAD_0BAD);    // read hit returns the word
		send_access(REQ_WRITE, 32'h0000_0000, 32'hDEAD_BEEF);   // write hit, only LRU moves
		send_access(REQ_LOOKUP, 32'h0000_0000, 32'h0);          // lookup hit, no data
		send_access(REQ_READ_WRITE, 32'h0000_0000, 32'h3333_3333); // both bits act as read
		send_access(REQ_READ, 32'h0000_0080, 32'h0000_0001);    // second tag, other way
		send_access(REQ_READ, 32'h0000_0100, 32'h0000_0002);    // third tag evicts the LRU
		send_access(REQ_READ, 32'h0000_0000, 32'h4444_4444);    // first tag now misses
		send_access(REQ_READ, 32'h0000_0080, 32'h5555_5555);    // whichever survived
		send_access(REQ_READ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // top set, top tag
		send_access(REQ_READ, 32'hFFFF_FFFF, 32'h0);
		send_access(REQ_WRITE, 32'hFFFF_FFFF, 32'h0);
		send_access(REQ_LOOKUP, 32'h0000_007F, 32'h0);          // top set, tag 0, still invalid
		send_access(REQ_READ, 32'hFFFF_FF80, 32'h0000_0000);    // set 0, top tag, zero fill
		send_access(REQ_WRITE, 32'h1234_5678, 32'h0);
		send_access(REQ_READ, 32'h5555_5555, 32'hAAAA_AAAA);
		send_access(REQ_READ, 32'hAAAA_AAAA, 32'h5555_5555);
		send_access(REQ_READ, 32'h5555_5555, 32'h0);
		send_access(REQ_READ, 32'hAAAA_AAAA, 32'hFFFF_FFFF);

		// sender pause: let everything drain before the random part
		pause_until_drained();

		// a small tag pool over a few sets keeps hits and evictions frequent
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		tag_pool[2] = TAG_W'($urandom);
		tag_pool[3] = TAG_W'($urandom);

		for (int i = 0; i < RANDOM_ACCESSES; i++) begin
			// long stretch with no idling at all
			jitter = !(i >= 450 && i < 650);

			// receiver holds off while requests keep coming, so the block backs up
			if (i == 300) hold_left = HOLD_OFF_CYCLES;

			// sender pause until the pipeline is empty
			if (i == 800) pause_until_drained();

			// one way hit over and over so the other way's age saturates
			if (i == 700) begin
				hot_a = {tag_pool[2], 7'd9};
				hot_b = {tag_pool[3], 7'd9};
				hot_c = {TAG_W'($urandom), 7'd9};
				send_access(REQ_READ, hot_a, $urandom);
				send_access(REQ_READ, hot_b, $urandom);
				for (int k = 0; k < SATURATE_HITS; k++)
					send_access(REQ_W'($urandom_range(0, 3)), hot_a, $urandom);
				send_access(REQ_READ, hot_c, $urandom);   // evicts the saturated way
				send_access(REQ_READ, hot_b, $urandom);
				send_access(REQ_READ, hot_a, $urandom);
			end

			if ($urandom_range(0, 99) < 75)
				addr = {tag_pool[$urandom_range(0, 3)], SET_W'($urandom_range(0, 3))};
			else
				addr = $urandom;
			// reads dominate so the store stays populated
			kind = ($urandom_range(0, 99) < 50) ? REQ_READ : REQ_W'($urandom_range(0, 3));
			send_access(kind, addr, $urandom);
		end

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d responses: %0d hits, %0d read-miss fills, %0d saturated ages",
			shadow.checked, shadow.hits, shadow.fills, shadow.saturations);
		$display("included a %0d-cycle receiver hold-off, drains and a no-idle stretch",
			HOLD_OFF_CYCLES);
		if (shadow.mismatches == 0 && shadow.pending_responses.size() == 0) begin
			$display("set_assoc_cache_lru_test passed");
		end else begin
			$display("set_assoc_cache_lru_test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
